// File: hdl/pidl_pkg.sv
// Package for the positional insert/delete list unit.
// Holds list sizing, operation and status codes, sequencer states and the
// request and response transaction types. No dependencies.
package pidl_pkg;

  // List sizing
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Requested operation
  typedef enum logic [2:0] {
    KIND_LIST      = 3'd0,
    KIND_INS_FRONT = 3'd1,
    KIND_INS_BACK  = 3'd2,
    KIND_INS_AT    = 3'd3,
    KIND_DEL_FRONT = 3'd4,
    KIND_DEL_BACK  = 3'd5,
    KIND_DEL_AT    = 3'd6
  } kind_t;

  // Result status
  typedef enum logic [2:0] {
    STAT_DONE   = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_BADPOS = 3'd3,
    STAT_NOLIST = 3'd4,
    STAT_ITEM   = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LIST,
    SEQ_SHIFT_UP,
    SEQ_SHIFT_DN
  } seq_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [6:0]         count_after;
    logic               last;
  } rsp_t;

endpackage

// File: hdl/positional_insert_delete_list_unit.sv
// Positional insert/delete list unit: entry memory, shift sequencer and
// two-deep response buffer. Depends on pidl_pkg.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values in a simple
// dual-port synchronous memory (one write and one read per cycle, registered
// read data). A request is accepted only while the sequencer is idle and
// the response skid slot is empty; a response left waiting in the output
// register does not block it. Every insert or delete answers with one status
// transaction carrying the new count, pushed into the response buffer at
// acceptance; the memory shift then runs in the background. An insert at p
// moves the entries from the top down to p up one slot (one entry moved per
// cycle, then the new value written at p), none at the end; a delete at p
// moves the entries above p down one slot, none when p is the last entry.
// A list request on n entries reads one entry per cycle and emits n element
// transactions, back to back while the consumer does not stall. These rates
// are set by the one read and one write the entry memory allows per cycle.
// Entries are never cleared; only entries below the count are read.
module positional_insert_delete_list_unit
  import pidl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Entry memory
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;

  // Sequencer registers
  seq_state_t         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      rem, rem_next;
  logic               rd_pend, rd_pend_next;
  logic [AW-1:0]      rd_tag, rd_tag_next;
  logic               lst_last, lst_last_next;
  logic [AW-1:0]      ins_pos, ins_pos_next;
  logic signed [31:0] ins_val, ins_val_next;

  // Response buffer
  logic pend_valid;
  rsp_t pend;
  logic push;
  rsp_t push_d;
  logic take;
  logic accept;

  assign take      = rsp_valid & ~rsp_stall;
  assign req_stall = (state != SEQ_IDLE) | pend_valid;
  assign accept    = req_valid & ~req_stall;

  // Read and write the entry memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SEQ_IDLE;
      count    <= '0;
      rem      <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rem      <= rem_next;
      rd_pend  <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    rd_tag   <= rd_tag_next;
    lst_last <= lst_last_next;
    ins_pos  <= ins_pos_next;
    ins_val  <= ins_val_next;
  end

  // Decode requests and step the shift and list sequences
  always_comb begin
    logic [CW-1:0] tgt;
    logic [CW-1:0] tmp;
    logic [1:0]    occ;
    status_t       st;

    tgt           = '0;
    tmp           = '0;
    occ           = 2'(rsp_valid) + 2'(pend_valid) + 2'(rd_pend) - 2'(take);
    st            = STAT_DONE;
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    rem_next      = rem;
    rd_pend_next  = 1'b0;
    rd_tag_next   = rd_tag;
    lst_last_next = lst_last;
    ins_pos_next  = ins_pos;
    ins_val_next  = ins_val;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = rd_tag;
    mem_raddr     = ptr;
    mem_wdata     = rdata;
    push          = 1'b0;
    push_d        = '{status: STAT_DONE, element: '0, element_index: '0,
                      count_after: '0, last: 1'b1};

    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (req.kind)
            KIND_LIST: begin
              if (count == '0) begin
                st = STAT_NOLIST;
              end else begin
                push       = 1'b0;
                ptr_next   = '0;
                rem_next   = count;
                state_next = SEQ_LIST;
              end
            end
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
              unique case (req.kind)
                KIND_INS_FRONT: tgt = '0;
                KIND_INS_BACK:  tgt = count;
                default:        tgt = CW'(req.position);
              endcase
              if (count >= CW'(DEPTH)) begin
                st = STAT_FULL;
              end else if (tgt > count) begin
                st = STAT_BADPOS;
              end else begin
                tmp          = count - CW'(1);
                count_next   = count + CW'(1);
                ptr_next     = tmp[AW-1:0];
                rem_next     = count - tgt;
                ins_pos_next = tgt[AW-1:0];
                ins_val_next = req.value;
                state_next   = SEQ_SHIFT_UP;
              end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
              unique case (req.kind)
                KIND_DEL_FRONT: tgt = '0;
                KIND_DEL_BACK:  tgt = count - CW'(1);
                default:        tgt = CW'(req.position);
              endcase
              if (count == '0 && req.kind != KIND_DEL_AT) begin
                st = STAT_EMPTY;
              end else if (tgt >= count) begin
                st = STAT_BADPOS;
              end else begin
                tmp        = tgt + CW'(1);
                count_next = count - CW'(1);
                ptr_next   = tmp[AW-1:0];
                rem_next   = count - tmp;
                state_next = (count == tmp) ? SEQ_IDLE : SEQ_SHIFT_DN;
              end
            end
            default: begin
              st = STAT_BADPOS;
            end
          endcase
          push_d.status      = st;
          push_d.count_after = count_next;
        end
      end

      SEQ_SHIFT_UP: begin
        // Move entry ptr up by one, then drop the new value in its slot
        if (rd_pend) begin
          mem_we = 1'b1;
        end
        if (rem != '0) begin
          mem_re       = 1'b1;
          ptr_next     = ptr - AW'(1);
          rem_next     = rem - CW'(1);
          rd_pend_next = 1'b1;
          rd_tag_next  = ptr + AW'(1);
        end else if (!rd_pend) begin
          mem_we     = 1'b1;
          mem_waddr  = ins_pos;
          mem_wdata  = ins_val;
          state_next = SEQ_IDLE;
        end
      end

      SEQ_SHIFT_DN: begin
        // Move entry ptr down by one until the top entry has moved
        if (rd_pend) begin
          mem_we = 1'b1;
        end
        if (rem != '0) begin
          mem_re       = 1'b1;
          ptr_next     = ptr + AW'(1);
          rem_next     = rem - CW'(1);
          rd_pend_next = 1'b1;
          rd_tag_next  = ptr - AW'(1);
        end else begin
          state_next = SEQ_IDLE;
        end
      end

      SEQ_LIST: begin
        // Emit the element read last cycle; read the next if space remains
        if (rd_pend) begin
          push                 = 1'b1;
          push_d.status        = STAT_ITEM;
          push_d.element       = rdata;
          push_d.element_index = rd_tag;
          push_d.count_after   = count;
          push_d.last          = lst_last;
        end
        if (rem != '0 && occ < 2'd2) begin
          mem_re        = 1'b1;
          ptr_next      = ptr + AW'(1);
          rem_next      = rem - CW'(1);
          rd_pend_next  = 1'b1;
          rd_tag_next   = ptr;
          lst_last_next = (rem == CW'(1));
        end
        if (rem == '0) begin
          state_next = SEQ_IDLE;
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  // Advance the two-deep response buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (take) begin
        rsp_valid  <= 1'b1;
        pend_valid <= push;
      end
    end else if (!rsp_valid || take) begin
      rsp_valid <= push;
    end else begin
      pend_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      if (take) begin
        rsp  <= pend;
        pend <= push_d;
      end
    end else if (!rsp_valid || take) begin
      rsp <= push_d;
    end else begin
      pend <= push_d;
    end
  end

endmodule

// File: hdl/pidl_checker.sv
// Port-level checker for the positional insert/delete list unit, bound to
// positional_insert_delete_list_unit. Depends on pidl_pkg.
module pidl_checker
  import pidl_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Hold a stalled response transaction
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Keep element fields clear on status transactions
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STAT_ITEM |->
      rsp.element == '0 && rsp.element_index == '0 && rsp.last)
    else $error("status transaction carries element data");

  // Keep listed indexes below the count
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_ITEM |->
      {1'b0, rsp.element_index} < rsp.count_after)
    else $error("listed index beyond count");

  // Keep the count within the list depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count_after <= 7'(DEPTH))
    else $error("count exceeds depth");

  // Drop all responses out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response right after reset");

endmodule

bind positional_insert_delete_list_unit pidl_checker u_pidl_checker (.*);
